// ----- design/rgb_led_spi_symbol_encoder_defines.svh -----
// ------------------------------------------------------------------
// rgb led spi encoder assertion macros
// shared check helpers, compiled out when NO_ASSERTIONS is set
// ------------------------------------------------------------------
`ifndef RGB_LED_SPI_SYMBOL_ENCODER_DEFINES_SVH
`define RGB_LED_SPI_SYMBOL_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define LEDSPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen out of reset
`define LEDSPI_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LEDSPI_ASSERT(lbl, prop, msg)
`define LEDSPI_NEVER(lbl, cond, msg)
`endif

`endif

// ----- design/ledspi_pkg.sv -----
// ------------------------------------------------------------------
// ledspi_pkg
// types, constants and helpers of the rgb led spi symbol encoder
// ------------------------------------------------------------------
package ledspi_pkg;

  localparam int MAX_PIXELS  = 64;
  localparam int POS_W       = $clog2(MAX_PIXELS);
  localparam int LVL_W       = 8;
  localparam int PCT_W       = 7;
  localparam int CNT_W       = 7;
  localparam int GAP_W       = 6;
  localparam int SYM_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = SYM_W * LVL_W;
  localparam int PROD_W      = LVL_W + PCT_W;
  localparam int PCT_MAX     = 100;
  localparam int GAP_LIMIT   = 55;
  // q = (p * RECIP) >> RECIP_SHIFT equals p / 100 for p below 2^15
  localparam int RECIP       = 5243;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam int SYM_BYTES   = 9;
  localparam int IDX_W       = 6;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_CNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SYM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SYM   = 3'd4;

  typedef struct packed {
    logic [LVL_W-1:0] red_level;
    logic [LVL_W-1:0] green_level;
    logic [LVL_W-1:0] blue_level;
  } pixel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] spi_byte;
    logic              is_gap;
    logic              run_end;
  } spi_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] blue;
    logic             last;
    logic [GAP_W-1:0] gap;
    logic [SYM_W-1:0] one_sym;
    logic [SYM_W-1:0] zero_sym;
  } job_t;

  function automatic logic [LVL_W-1:0] div100(input logic [PROD_W-1:0] prod);
    logic [PROD_W+RECIP_W-1:0] p;
    p = (PROD_W+RECIP_W)'(prod) * (PROD_W+RECIP_W)'(RECIP);
    return p[RECIP_SHIFT +: LVL_W];
  endfunction

  function automatic logic [WORD_W-1:0] make_word(input logic [LVL_W-1:0] lvl,
                                                  input logic [SYM_W-1:0] hi,
                                                  input logic [SYM_W-1:0] lo);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int i = 0; i < LVL_W; i++) begin
      w[i*SYM_W +: SYM_W] = lvl[i] ? hi : lo;
    end
    return w;
  endfunction

endpackage

// ----- design/ledspi_front.sv -----
// ------------------------------------------------------------------
// ledspi_front
// config registers, pixel intake, brightness scaling, frame position
// ------------------------------------------------------------------
module ledspi_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ledspi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ledspi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                                in_push,
  input  ledspi_pkg::pixel_t                  in_data,
  output logic                                in_full,
  input  logic                                q_full,
  output logic                                q_push,
  output ledspi_pkg::job_t                    q_data
);
  import ledspi_pkg::*;

  logic [PCT_W-1:0]  brt_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [GAP_W-1:0]  gapcfg_r;
  logic [SYM_W-1:0]  one_r;
  logic [SYM_W-1:0]  zero_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  logic [PROD_W-1:0] prod_g_r, prod_r_r, prod_b_r;
  logic              s1_last_r;
  logic [GAP_W-1:0]  s1_gap_r;
  logic [SYM_W-1:0]  s1_one_r, s1_zero_r;

  logic              accept;
  logic [PCT_W-1:0]  pct;
  logic [CNT_W-1:0]  cnt_eff;
  logic [GAP_W-1:0]  gap_eff;
  logic              last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brt_r    <= PCT_W'(PCT_MAX);
      cnt_r    <= CNT_W'(MAX_PIXELS);
      gapcfg_r <= GAP_W'(16);
      one_r    <= SYM_W'(6);
      zero_r   <= SYM_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BRIGHTNESS:  brt_r    <= cfg_wdata[PCT_W-1:0];
        REG_PIXEL_CNT:   cnt_r    <= cfg_wdata[CNT_W-1:0];
        REG_RESET_BYTES: gapcfg_r <= cfg_wdata[GAP_W-1:0];
        REG_ONE_SYM:     one_r    <= cfg_wdata[SYM_W-1:0];
        REG_ZERO_SYM:    zero_r   <= cfg_wdata[SYM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pct = (brt_r > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : brt_r;
    if (cnt_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (cnt_r > CNT_W'(MAX_PIXELS)) begin
      cnt_eff = CNT_W'(MAX_PIXELS);
    end else begin
      cnt_eff = cnt_r;
    end
    if (gapcfg_r == '0) begin
      gap_eff = GAP_W'(1);
    end else if (gapcfg_r > GAP_W'(GAP_LIMIT)) begin
      gap_eff = GAP_W'(GAP_LIMIT);
    end else begin
      gap_eff = gapcfg_r;
    end
    // a lowered count mid-frame also ends the frame
    last = (CNT_W'(pos_r) + CNT_W'(1)) >= cnt_eff;
  end

  assign in_full = s1_valid_r & q_full;
  assign accept  = in_push & ~in_full;
  assign q_push  = s1_valid_r & ~q_full;

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = last ? '0 : pos_r + POS_W'(1);
    end
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_g_r  <= PROD_W'(in_data.green_level) * PROD_W'(pct);
      prod_r_r  <= PROD_W'(in_data.red_level) * PROD_W'(pct);
      prod_b_r  <= PROD_W'(in_data.blue_level) * PROD_W'(pct);
      s1_last_r <= last;
      s1_gap_r  <= gap_eff;
      s1_one_r  <= one_r;
      s1_zero_r <= zero_r;
    end
  end

  always_comb begin
    q_data.green    = div100(prod_g_r);
    q_data.red      = div100(prod_r_r);
    q_data.blue     = div100(prod_b_r);
    q_data.last     = s1_last_r;
    q_data.gap      = s1_gap_r;
    q_data.one_sym  = s1_one_r;
    q_data.zero_sym = s1_zero_r;
  end

endmodule

// ----- design/ledspi_queue.sv -----
`include "rgb_led_spi_symbol_encoder_defines.svh"
// ------------------------------------------------------------------
// ledspi_queue
// short request queue between front and back
// ------------------------------------------------------------------
module ledspi_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ledspi_pkg::job_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output ledspi_pkg::job_t head
);
  import ledspi_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_r <= wr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= rd_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  `LEDSPI_NEVER(a_q_overfill, cnt_r > QCNT_W'(QDEPTH), "queue count above depth")
  `LEDSPI_NEVER(a_q_push_full, push && full, "front pushed into a full queue")
  `LEDSPI_ASSERT(a_q_ptr_gap, (cnt_r == '0 || cnt_r == QCNT_W'(QDEPTH)) |-> (wr_r == rd_r), "queue pointers disagree with count")

endmodule

// ----- design/ledspi_back.sv -----
`include "rgb_led_spi_symbol_encoder_defines.svh"
// ------------------------------------------------------------------
// ledspi_back
// turns each queued request into symbol bytes, plus gap bytes after the pixel that ends a frame
// ------------------------------------------------------------------
module ledspi_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  ledspi_pkg::job_t     q_head,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output ledspi_pkg::spi_out_t out_data
);
  import ledspi_pkg::*;

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  spi_out_t          out_r;

  logic              load;
  logic              in_gap;
  logic              final_byte;
  logic [IDX_W-1:0]  end_idx;
  logic [1:0]        chan;
  logic [1:0]        bsel;
  logic [LVL_W-1:0]  lvl;
  logic [WORD_W-1:0] word;
  logic [BYTE_W-1:0] sym_byte;
  spi_out_t          nxt_byte;

  assign load = ~q_empty & (~out_valid_r | out_pop);

  always_comb begin
    in_gap  = idx_r >= IDX_W'(SYM_BYTES);
    end_idx = q_head.last ? IDX_W'(SYM_BYTES - 1) + IDX_W'(q_head.gap)
                          : IDX_W'(SYM_BYTES - 1);
    final_byte = (idx_r == end_idx);

    // green, red, blue; three bytes per channel
    if (idx_r < IDX_W'(3)) begin
      chan = 2'd0;
      bsel = idx_r[1:0];
    end else if (idx_r < IDX_W'(6)) begin
      chan = 2'd1;
      bsel = 2'(idx_r - IDX_W'(3));
    end else begin
      chan = 2'd2;
      bsel = 2'(idx_r - IDX_W'(6));
    end

    case (chan)
      2'd0:    lvl = q_head.green;
      2'd1:    lvl = q_head.red;
      default: lvl = q_head.blue;
    endcase
    word = make_word(lvl, q_head.one_sym, q_head.zero_sym);

    case (bsel)
      2'd0:    sym_byte = word[23:16];
      2'd1:    sym_byte = word[15:8];
      default: sym_byte = word[7:0];
    endcase

    nxt_byte.spi_byte = in_gap ? '0 : sym_byte;
    nxt_byte.is_gap   = in_gap;
    nxt_byte.run_end  = final_byte;
  end

  assign q_pop = load & final_byte;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = final_byte ? '0 : idx_r + IDX_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= nxt_byte;
    end
  end

  assign out_empty = ~out_valid_r;
  assign out_data  = out_r;

  `LEDSPI_ASSERT(a_mid_request_held, (idx_r != '0) |-> !q_empty, "request left queue before its last byte")
  `LEDSPI_ASSERT(a_gap_only_last, (load && in_gap) |-> q_head.last, "gap byte on a pixel that does not end the frame")
  `LEDSPI_ASSERT(a_pop_restarts, q_pop |=> (idx_r == '0), "byte index not restarted after request done")

endmodule

// ----- design/rgb_led_spi_symbol_encoder.sv -----
// ------------------------------------------------------------------
// rgb_led_spi_symbol_encoder
// pixel to spi byte encoder for addressable rgb leds, 3-bit symbols
// ------------------------------------------------------------------
// a pixel is registered in the front stage, queued, then sent via the output byte register
// one byte per cycle from the single output byte register while out_pop takes each byte;
//   a pixel gives 9 symbol bytes, or 9 + gap length bytes when it ends the frame
// the front takes a new pixel while the back still sends the previous ones (2-deep queue)
// reset: synchronous active-low rst_n; config back to defaults, frame position zero, empty
module rgb_led_spi_symbol_encoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ledspi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ledspi_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                              in_push,
  input  ledspi_pkg::pixel_t                in_data,
  output logic                              in_full,
  input  logic                              out_pop,
  output ledspi_pkg::spi_out_t              out_data,
  output logic                              out_empty
);
  import ledspi_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t q_wdata, q_head;

  ledspi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  ledspi_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  ledspi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
